### rtl/core/debounced_input_press_timer_top_macros.svh
// Assertion macros shared by the press timer RTL.
`ifndef DEBOUNCED_INPUT_PRESS_TIMER_TOP_MACROS_SVH
`define DEBOUNCED_INPUT_PRESS_TIMER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DIPT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: lbl");

// Next-cycle implication, disabled during reset.
`define DIPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: lbl");

`endif

### rtl/core/dipt_pkg.sv
// Constants and register indexes for the debounced press timer.
package dipt_pkg;

   localparam int unsigned TsW      = 32;
   localparam int unsigned DebW     = 8;
   localparam int unsigned DelayW   = 16;
   localparam int unsigned ThrW     = 26;   // 65535 * 1000 fits in 26 bits
   localparam int unsigned CsrAddrW = 2;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned ReqDataW = 40;   // raw_level + timestamp, byte padded
   localparam int unsigned RspDataW = 40;   // 35 bits of fields, byte padded

   localparam logic [ThrW-1:0] UsPerMs = ThrW'(1000);

   typedef enum logic [CsrAddrW-1:0] {
      CSR_INVERT_LEVEL  = 2'd0,
      CSR_DEBOUNCE      = 2'd1,
      CSR_EMERG_ENABLE  = 2'd2,
      CSR_EMERG_DELAY   = 2'd3
   } csr_addr_type;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_EMERG  = 1'b1;

endpackage

### rtl/core/debounced_input_press_timer_top.sv
// Debounced input with press-duration timer and sticky emergency flag.
//
// Input stream req_*: tuser carries the command (sample or read-and-clear
// emergency); tdata carries the raw level and a 32-bit microsecond timestamp.
// Output stream rsp_*: one result transaction per input transaction, carrying
// the change flag, the logical level, the release duration and the emergency
// read-back.
// The result passes through one input register, then the result register.
// Throughput: one transaction per cycle while rsp_tready is high. The debounce
// counter, edge detector and duration subtract all settle between the two registers.
// When the receiver stalls, the result register holds and the input register
// can still take one more transaction; after that req_tready drops.
// Reset (synchronous, active high) clears both stages, the filter and timing
// state and the configuration (debounce setting 1, others 0).
// csr_*: write-only register port, taken on any cycle with csr_we high; write
// only while the block is idle. The emergency threshold in microseconds is
// computed when csr register 3 is written.
module debounced_input_press_timer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dipt_pkg::ReqDataW-1:0]    req_tdata,  // [0] raw_level, [32:1] timestamp_us
   input  logic                             req_tuser,  // [0] cmd
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] changed, [1] active_level, [33:2] duration_us, [34] emergency_was_pending
   output logic [dipt_pkg::RspDataW-1:0]    rsp_tdata,
   input  logic                             csr_we,
   input  logic [dipt_pkg::CsrAddrW-1:0]    csr_addr,
   input  logic [dipt_pkg::CsrDataW-1:0]    csr_wdata
);

`include "debounced_input_press_timer_top_macros.svh"

   // configuration
   logic                          inv_ff;
   logic [dipt_pkg::DebW-1:0]     deb_ff;
   logic                          emen_ff;
   logic [dipt_pkg::ThrW-1:0]     thr_ff;

   // input stage
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_cmd_ff;
   logic                          s1_raw_ff;
   logic [dipt_pkg::TsW-1:0]      s1_ts_ff;

   // block state
   logic                          active_ff, active_in;
   logic [dipt_pkg::TsW-1:0]      start_ff, start_in;
   logic                          cand_ff, cand_in;
   logic [dipt_pkg::DebW-1:0]     cnt_ff, cnt_in;
   logic                          emerg_ff, emerg_in;

   // result stage
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          changed_ff, changed_in;
   logic                          level_ff;
   logic [dipt_pkg::TsW-1:0]      dur_ff, dur_in;
   logic                          was_ff, was_in;

   logic                          req_fire;
   logic                          s1_fire;
   logic                          take;
   logic                          logical;
   logic [dipt_pkg::TsW-1:0]      diff;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, was_ff, dur_ff, level_ff, changed_ff};

   assign logical = s1_raw_ff ^ inv_ff;
   assign diff    = s1_ts_ff - start_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State update for the transaction leaving the input stage
   always_comb begin
      active_in  = active_ff;
      start_in   = start_ff;
      cand_in    = cand_ff;
      cnt_in     = cnt_ff;
      emerg_in   = emerg_ff;
      changed_in = 1'b0;
      dur_in     = '0;
      was_in     = 1'b0;
      take       = 1'b0;
      if (s1_fire) begin
         if (s1_cmd_ff == dipt_pkg::CMD_EMERG) begin
            was_in   = emerg_ff;
            emerg_in = 1'b0;
         end else begin
            if (deb_ff[dipt_pkg::DebW-1:1] == '0) begin
               take = 1'b1;   // filter bypassed
            end else begin
               if (s1_raw_ff != cand_ff) begin
                  cand_in = s1_raw_ff;
                  cnt_in  = dipt_pkg::DebW'(1);
               end else if (cnt_ff < deb_ff) begin
                  cnt_in = cnt_ff + dipt_pkg::DebW'(1);
               end
               take = (cnt_in >= deb_ff);
            end
            if (take && (logical != active_ff)) begin
               changed_in = 1'b1;
               active_in  = logical;
               if (logical) begin
                  start_in = s1_ts_ff;
               end else begin
                  dur_in = diff;
                  if (emen_ff && (diff >= dipt_pkg::TsW'(thr_ff))) begin
                     emerg_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff       <= 1'b0;
         deb_ff       <= dipt_pkg::DebW'(1);
         emen_ff      <= 1'b0;
         thr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         start_ff     <= '0;
         cand_ff      <= 1'b0;
         cnt_ff       <= '0;
         emerg_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         start_ff     <= start_in;
         cand_ff      <= cand_in;
         cnt_ff       <= cnt_in;
         emerg_ff     <= emerg_in;
         if (csr_we) begin
            case (dipt_pkg::csr_addr_type'(csr_addr))
               dipt_pkg::CSR_INVERT_LEVEL: inv_ff  <= csr_wdata[0];
               dipt_pkg::CSR_DEBOUNCE:     deb_ff  <= csr_wdata[dipt_pkg::DebW-1:0];
               dipt_pkg::CSR_EMERG_ENABLE: emen_ff <= csr_wdata[0];
               dipt_pkg::CSR_EMERG_DELAY:
                  thr_ff <= dipt_pkg::ThrW'(csr_wdata) * dipt_pkg::UsPerMs;
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff <= req_tuser;
         s1_raw_ff <= req_tdata[0];
         s1_ts_ff  <= req_tdata[dipt_pkg::TsW:1];
      end
      if (s1_fire) begin
         changed_ff <= changed_in;
         level_ff   <= active_in;
         dur_ff     <= dur_in;
         was_ff     <= was_in;
      end
   end

   // duration only on a real release edge
   `DIPT_ASSERT_SAME(a_dur_needs_change, clock, reset,
      rsp_valid_ff && !changed_ff, dur_ff == '0)
   // an emergency read never reports an edge
   `DIPT_ASSERT_SAME(a_was_no_edge, clock, reset,
      rsp_valid_ff && was_ff, !changed_ff && dur_ff == '0)
   // the read-and-clear command leaves the flag cleared
   `DIPT_ASSERT_NEXT(a_emerg_cleared, clock, reset,
      s1_fire && s1_cmd_ff == dipt_pkg::CMD_EMERG, !emerg_ff)
   // the reported level tracks the held state
   `DIPT_ASSERT_NEXT(a_level_tracks, clock, reset,
      s1_fire, level_ff == active_ff)

endmodule
